// ===== src/sfre_pkg.sv =====
// Shared types, constants and helpers for the SPI flash read engine.
// Used by every module under src but sfre_checker; depends on nothing else.
package sfre_pkg;

	localparam int DEF_SELECT_LINES = 4;
	localparam int HEADER_BYTES = 4;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [7:0] READ_OPCODE = 8'h03;
	localparam logic [24:0] MAX_COUNT = 25'h100_0000;

	typedef enum logic {
		KIND_START = 1'b0,
		KIND_RX    = 1'b1
	} kind_e_t;

	typedef enum logic {
		REG_WORD_SIZE   = 1'b0,
		REG_SELECT_MASK = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		WS_8   = 2'd0,
		WS_16  = 2'd1,
		WS_32  = 2'd2,
		WS_RSV = 2'd3
	} word_size_t;

	// One classified word as it waits between the front and the back.
	typedef struct packed {
		logic        is_start;
		logic [23:0] offset;
		logic [24:0] count;
		logic [31:0] rx;
	} item_t;

	// Queue status seen by the front.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef struct packed {
		logic [31:0] tx_word;
		logic        tx_valid;
		logic [31:0] data_word;
		logic [2:0]  data_bytes;
		logic        done_res;
	} result_t;

	function automatic logic [2:0] word_bytes(input logic [1:0] ws);
		logic [2:0] w;
		unique case (word_size_t'(ws))
			WS_8:    w = 3'd1;
			WS_16:   w = 3'd2;
			WS_32:   w = 3'd4;
			default: w = 3'd4;
		endcase
		return w;
	endfunction

	// Mask covering the n low bytes of a 32-bit word.
	function automatic logic [31:0] byte_mask(input logic [2:0] n);
		logic [31:0] m;
		unique case (n)
			3'd0:    m = 32'h0000_0000;
			3'd1:    m = 32'h0000_00ff;
			3'd2:    m = 32'h0000_ffff;
			3'd3:    m = 32'h00ff_ffff;
			default: m = 32'hffff_ffff;
		endcase
		return m;
	endfunction

endpackage

// ===== src/sfre_front.sv =====
// Front end: accepts input words, classifies them and saturates the count.
// Depends on sfre_pkg; feeds sfre_queue.
module sfre_front (
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 kind,
	input  logic [23:0]          flash_offset,
	input  logic [24:0]          byte_count,
	input  logic [31:0]          rx_word,
	input  sfre_pkg::queue_stat_t qstat,
	output logic                 push,
	output sfre_pkg::item_t      push_item
);

	assign in_ready = !qstat.full;
	assign push = in_valid && !qstat.full;

	always_comb begin
		push_item.is_start = (sfre_pkg::kind_e_t'(kind) == sfre_pkg::KIND_START);
		push_item.offset = flash_offset;
		push_item.count = (byte_count > sfre_pkg::MAX_COUNT) ? sfre_pkg::MAX_COUNT : byte_count;
		push_item.rx = rx_word;
	end

endmodule

// ===== src/sfre_queue.sv =====
// Short queue of classified words between the front and the back.
// Depends on sfre_pkg.
module sfre_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  sfre_pkg::item_t       push_item,
	input  logic                  pop,
	output logic                  head_valid,
	output sfre_pkg::item_t       head_item,
	output sfre_pkg::queue_stat_t qstat
);

	localparam int Depth = sfre_pkg::QUEUE_DEPTH;
	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	sfre_pkg::item_t entry_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] fill_q;

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		logic [PtrW-1:0] n;
		if (p == PtrW'(Depth - 1)) begin
			n = '0;
		end else begin
			n = p + PtrW'(1);
		end
		return n;
	endfunction

	assign qstat.full = (fill_q == CntW'(Depth));
	assign qstat.empty = (fill_q == '0);
	assign head_valid = !qstat.empty;
	assign head_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CntW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== src/sfre_back.sv =====
// Back end: runs the read sequence on each queued word and holds the result
// in an output register. Depends on sfre_pkg; fed by sfre_queue.
module sfre_back #(
	parameter int SELECT_LINES = sfre_pkg::DEF_SELECT_LINES
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [1:0]              word_size,
	input  logic [SELECT_LINES-1:0] select_mask,
	input  logic                    head_valid,
	input  sfre_pkg::item_t         head_item,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output sfre_pkg::result_t       result,
	output logic [SELECT_LINES-1:0] select_lines
);

	localparam logic [24:0] HdrBytes = 25'(sfre_pkg::HEADER_BYTES);

	logic        busy_q;
	logic [23:0] offset_q;
	logic [24:0] count_q;
	logic [24:0] total_q;
	logic [24:0] sent_q;
	logic [24:0] rcv_q;
	logic [24:0] del_q;

	logic                    out_valid_q;
	sfre_pkg::result_t       result_q;
	logic [SELECT_LINES-1:0] sel_q;

	logic [2:0]        w;
	logic [24:0]       w_ext;
	logic [24:0]       left;
	logic [24:0]       rcv_next;
	logic              take;
	logic              busy_d;
	logic [23:0]       offset_d;
	logic [24:0]       count_d;
	logic [24:0]       total_d;
	logic [24:0]       sent_d;
	logic [24:0]       rcv_d;
	logic [24:0]       del_d;
	sfre_pkg::result_t res_d;
	logic [31:0]       hdr_word;
	logic [31:0]       hdr_shift;
	logic [31:0]       tx_at_sent;
	logic [31:0]       tx_at_zero;

	assign pop = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign result = result_q;
	assign select_lines = sel_q;

	assign w = sfre_pkg::word_bytes(word_size);
	assign w_ext = {22'd0, w};

	// Header bytes as they stand in the stream, opcode first. A slot that starts
	// past the header carries only padding.
	always_comb begin
		hdr_word = {sfre_pkg::READ_OPCODE, offset_q};
		hdr_shift = hdr_word << {sent_q[1:0], 3'b000};
		if (sent_q >= HdrBytes) begin
			tx_at_sent = '0;
		end else begin
			tx_at_sent = hdr_shift >> {3'd4 - w, 3'b000};
		end
		tx_at_zero = {sfre_pkg::READ_OPCODE, head_item.offset} >> {3'd4 - w, 3'b000};
	end

	always_comb begin
		busy_d = busy_q;
		offset_d = offset_q;
		count_d = count_q;
		total_d = total_q;
		sent_d = sent_q;
		rcv_d = rcv_q;
		del_d = del_q;
		res_d = '0;
		take = 1'b0;
		left = count_q - del_q;
		rcv_next = rcv_q + w_ext;
		if (head_item.is_start) begin
			offset_d = head_item.offset;
			count_d = head_item.count;
			total_d = head_item.count + HdrBytes;
			rcv_d = '0;
			del_d = '0;
			busy_d = 1'b1;
			sent_d = w_ext;
			res_d.tx_word = tx_at_zero;
			res_d.tx_valid = 1'b1;
		end else if (busy_q) begin
			take = (rcv_q >= HdrBytes) && (del_q < count_q);
			if (take) begin
				res_d.data_bytes = (left < w_ext) ? left[2:0] : w;
				res_d.data_word = head_item.rx & sfre_pkg::byte_mask(w)
					& ~sfre_pkg::byte_mask(w - res_d.data_bytes);
				del_d = del_q + {22'd0, res_d.data_bytes};
			end
			rcv_d = rcv_next;
			if (rcv_next >= total_q) begin
				busy_d = 1'b0;
				res_d.done_res = 1'b1;
			end else if (sent_q < total_q) begin
				res_d.tx_word = tx_at_sent;
				res_d.tx_valid = 1'b1;
				sent_d = sent_q + w_ext;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			offset_q <= '0;
			count_q <= '0;
			total_q <= HdrBytes;
			sent_q <= '0;
			rcv_q <= '0;
			del_q <= '0;
			out_valid_q <= 1'b0;
			sel_q <= '1;
		end else begin
			if (pop) begin
				busy_q <= busy_d;
				offset_q <= offset_d;
				count_q <= count_d;
				total_q <= total_d;
				sent_q <= sent_d;
				rcv_q <= rcv_d;
				del_q <= del_d;
				out_valid_q <= 1'b1;
				sel_q <= busy_d ? ~select_mask : '1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q <= res_d;
		end
	end

endmodule

// ===== src/spi_flash_read_engine_core.sv =====
// Top level of the SPI flash read engine (read command 0x03).
// Depends on sfre_pkg, sfre_front, sfre_queue and sfre_back.
//
// Usage: each input word is either a start (kind 0, with flash_offset and
// byte_count) or a word received from the shifter (kind 1, rx_word). Every
// accepted word gives exactly one result word: the next transmit word with
// tx_valid, the active-low device selects, any read data bytes with their
// count, and done_res on the word that completes the transfer.
// The front accepts a word whenever the two-entry queue has room; the back
// takes one queued word per cycle into the output register whenever it is
// empty or the receiver takes its result. Each word passes the queue and
// the output register, at one word per cycle while results are taken.
// When the receiver stalls, the result waits in the output register and the
// queue keeps taking words until both of its entries are full; in_ready then
// drops until the receiver takes the result.
// Configuration writes (word_size at index 0, select_mask at index 1) take
// effect at the next clock edge and must only be issued while no word is in
// flight. Reset empties the queue, drops out_valid, resets the transfer
// state, clears both configuration registers and leaves the device deselected.
module spi_flash_read_engine_core #(
	parameter int SELECT_LINES = sfre_pkg::DEF_SELECT_LINES,
	localparam int CFG_W = (SELECT_LINES > 2) ? SELECT_LINES : 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    kind,
	input  logic [23:0]             flash_offset,
	input  logic [24:0]             byte_count,
	input  logic [31:0]             rx_word,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [31:0]             tx_word,
	output logic                    tx_valid,
	output logic [SELECT_LINES-1:0] select_lines,
	output logic [31:0]             data_word,
	output logic [2:0]              data_bytes,
	output logic                    done_res
);

	logic [1:0]              word_size_q;
	logic [SELECT_LINES-1:0] select_mask_q;

	sfre_pkg::queue_stat_t qstat;
	sfre_pkg::item_t       push_item;
	sfre_pkg::item_t       head_item;
	sfre_pkg::result_t     result;
	logic                  push;
	logic                  pop;
	logic                  head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_size_q <= '0;
			select_mask_q <= '0;
		end else if (cfg_we) begin
			unique case (sfre_pkg::cfg_reg_t'(cfg_index))
				sfre_pkg::REG_WORD_SIZE:   word_size_q <= cfg_data[1:0];
				sfre_pkg::REG_SELECT_MASK: select_mask_q <= cfg_data[SELECT_LINES-1:0];
				default: ;
			endcase
		end
	end

	sfre_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.flash_offset (flash_offset),
		.byte_count   (byte_count),
		.rx_word      (rx_word),
		.qstat        (qstat),
		.push         (push),
		.push_item    (push_item)
	);

	sfre_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item),
		.qstat      (qstat)
	);

	sfre_back #(
		.SELECT_LINES (SELECT_LINES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_size    (word_size_q),
		.select_mask  (select_mask_q),
		.head_valid   (head_valid),
		.head_item    (head_item),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result       (result),
		.select_lines (select_lines)
	);

	assign tx_word = result.tx_word;
	assign tx_valid = result.tx_valid;
	assign data_word = result.data_word;
	assign data_bytes = result.data_bytes;
	assign done_res = result.done_res;

endmodule

// ===== src/sfre_checker.sv =====
// Port-level checks for the SPI flash read engine, bound to the top level.
// Depends on spi_flash_read_engine_core.
module sfre_checker #(
	parameter int SELECT_LINES = 4
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [31:0]             tx_word,
	input logic                    tx_valid,
	input logic [SELECT_LINES-1:0] select_lines,
	input logic [31:0]             data_word,
	input logic [2:0]              data_bytes,
	input logic                    done_res
);

	// A result word must stay offered until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped before it was taken");

	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> tx_word == 32'd0)
		else $error("transmit word not zero without tx_valid");

	// The word that completes a transfer deselects every device and sends nothing.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> (&select_lines) && !tx_valid)
		else $error("done reported while still selecting or sending");

	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> data_bytes <= 3'd4 && (data_bytes != 3'd0 || data_word == 32'd0))
		else $error("data byte count out of range or stray data");

endmodule

bind spi_flash_read_engine_core sfre_checker #(
	.SELECT_LINES (SELECT_LINES)
) u_sfre_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.tx_word      (tx_word),
	.tx_valid     (tx_valid),
	.select_lines (select_lines),
	.data_word    (data_word),
	.data_bytes   (data_bytes),
	.done_res     (done_res)
);
